>>> rtl/sphere_angle_to_ring_pixel_assert.svh
// assertion macros shared by the ring pixel pipeline modules
`ifndef SPHERE_ANGLE_TO_RING_PIXEL_ASSERT_SVH
`define SPHERE_ANGLE_TO_RING_PIXEL_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SARP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sarp check failed");

// next-cycle implication, checked outside reset
`define SARP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sarp check failed");

`endif

>>> rtl/sarp_pkg.sv
// shared types and constants of the ring pixel pipeline
`default_nettype none
package sarp_pkg;
    localparam int unsigned RES_W   = 14;
    localparam int unsigned Z_W     = 32;
    localparam int unsigned A_W     = 32;
    localparam int unsigned PIX_W   = 30;
    localparam int unsigned MAX_RES = 8192;
    localparam int unsigned W_W     = 30;
    localparam int unsigned ROOT_W  = 31;
    localparam int unsigned REM_W   = 33;
    localparam int unsigned SQ_STEPS = ROOT_W;
    localparam int unsigned NSQ_W   = 2 * RES_W;

    // per-item fields that ride alongside the root unit
    typedef struct packed {
        logic [PIX_W-1:0] pix_e;
        logic             eq;
        logic             north;
        logic [A_W-1:0]   a;
        logic [RES_W-1:0] n;
        logic [NSQ_W-1:0] nsq;
    } t_side;
endpackage
`default_nettype wire

>>> rtl/sarp_equ.sv
// front stages: saturation, branch test, equatorial pixel and polar root operand
`default_nettype none
module sarp_equ
    import sarp_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire logic [Z_W-1:0]   i_z,
    input  wire logic [A_W-1:0]   i_a,
    input  wire logic [RES_W-1:0] i_n,
    output logic                  o_valid,
    output logic [W_W-1:0]        o_w,
    output t_side                 o_side
);
    // stage 1: saturated cos theta
    logic r1_v;
    logic [Z_W-1:0] r1_z, n_z1;
    logic [A_W-1:0] r1_a;
    logic [RES_W-1:0] r1_n;

    always_comb begin
        if (!i_z[31] && (i_z > 32'h4000_0000)) begin
            n_z1 = 32'h4000_0000;
        end else if (i_z[31] && (i_z < 32'hC000_0000)) begin
            n_z1 = 32'hC000_0000;
        end else begin
            n_z1 = i_z;
        end
    end

    // stage 2: edge operands, branch flag, root operand
    logic r2_v, r2_eq, r2_north;
    logic [34:0] r2_up, r2_dn;
    logic [W_W-1:0] r2_w;
    logic [A_W-1:0] r2_a;
    logic [RES_W-1:0] r2_n;
    logic [31:0] zabs, za3, w3;
    logic [30:0] za31, dz;
    logic [33:0] z3;
    logic [36:0] base, up37, dn37;

    always_comb begin
        zabs = r1_z[31] ? (~r1_z + 32'd1) : r1_z;
        za31 = zabs[30:0];
        za3  = {za31, 1'b0} + {1'b0, za31};
        z3   = {{2{r1_z[31]}}, r1_z} + {r1_z[31], r1_z, 1'b0};
        base = {3'b000, r1_a, 2'b00} + 37'h0_8000_0000;
        up37 = base - {{3{z3[33]}}, z3};
        dn37 = base + {{3{z3[33]}}, z3};
        dz   = 31'h4000_0000 - za31;
        w3   = {dz, 1'b0} + {1'b0, dz};
    end

    // stage 3: edge line indexes
    logic r3_v, r3_eq, r3_north;
    logic [16:0] r3_jp, r3_jm;
    logic [W_W-1:0] r3_w;
    logic [A_W-1:0] r3_a;
    logic [RES_W-1:0] r3_n;
    logic [48:0] pu, pd;

    assign pu = r2_n * r2_up;
    assign pd = r2_n * r2_dn;

    // stage 4: ring number and position in ring
    logic r4_v, r4_eq, r4_north;
    logic [14:0] r4_ir, r4_ip;
    logic [W_W-1:0] r4_w;
    logic [A_W-1:0] r4_a;
    logic [RES_W-1:0] r4_n;
    logic [18:0] ir19, s19;
    logic [17:0] ipr, n4, ip18;
    logic ksh;

    always_comb begin
        ir19 = {5'b0, r3_n} + 19'd1 + {2'b0, r3_jp} - {2'b0, r3_jm};
        ksh  = ~ir19[0];
        s19  = {2'b0, r3_jp} + {2'b0, r3_jm} + {18'b0, ksh} + 19'd1 - {5'b0, r3_n};
        ipr  = s19[18:1];
        n4   = {2'b0, r3_n, 2'b00};
        ip18 = (ipr >= n4) ? (ipr - n4) : ipr;
    end

    // stage 5: offset products
    logic r5_v, r5_eq, r5_north;
    logic [27:0] r5_m1;
    logic [28:0] r5_m2;
    logic [NSQ_W-1:0] r5_nsq;
    logic [14:0] r5_ip;
    logic [W_W-1:0] r5_w;
    logic [A_W-1:0] r5_a;
    logic [RES_W-1:0] r5_n;

    // stage 6: equatorial pixel
    logic r6_v;
    t_side r6_side;
    logic [W_W-1:0] r6_w;
    logic [PIX_W-1:0] pix_e;

    assign pix_e = 30'({r5_m1, 1'b0}) + 30'({r5_m2, 2'b00}) + 30'(r5_ip);

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_z <= n_z1;
            r1_a <= i_a;
            r1_n <= i_n;

            r2_eq    <= (za3 <= 32'h8000_0000);
            r2_north <= !r1_z[31] && (r1_z != '0);
            r2_up    <= up37[34:0];
            r2_dn    <= dn37[34:0];
            r2_w     <= w3[W_W-1:0];
            r2_a     <= r1_a;
            r2_n     <= r1_n;

            r3_eq    <= r2_eq;
            r3_north <= r2_north;
            r3_jp    <= pu[48:32];
            r3_jm    <= pd[48:32];
            r3_w     <= r2_w;
            r3_a     <= r2_a;
            r3_n     <= r2_n;

            r4_eq    <= r3_eq;
            r4_north <= r3_north;
            r4_ir    <= ir19[14:0];
            r4_ip    <= ip18[14:0];
            r4_w     <= r3_w;
            r4_a     <= r3_a;
            r4_n     <= r3_n;

            r5_eq    <= r4_eq;
            r5_north <= r4_north;
            r5_m1    <= r4_n * (r4_n - 14'd1);
            r5_m2    <= (r4_ir - 15'd1) * r4_n;
            r5_nsq   <= r4_n * r4_n;
            r5_ip    <= r4_ip;
            r5_w     <= r4_w;
            r5_a     <= r4_a;
            r5_n     <= r4_n;

            r6_side.pix_e <= pix_e;
            r6_side.eq    <= r5_eq;
            r6_side.north <= r5_north;
            r6_side.a     <= r5_a;
            r6_side.n     <= r5_n;
            r6_side.nsq   <= r5_nsq;
            r6_w          <= r5_w;
        end
    end

    assign o_valid = r6_v;
    assign o_w     = r6_w;
    assign o_side  = r6_side;
endmodule
`default_nettype wire

>>> rtl/sarp_sqrt.sv
// pipelined integer square root of w * 2^32, one root bit per stage
`default_nettype none
module sarp_sqrt
    import sarp_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire logic [W_W-1:0] i_w,
    input  t_side              i_side,
    output logic               o_valid,
    output logic [ROOT_W-1:0]  o_root,
    output t_side              o_side
);
`include "sphere_angle_to_ring_pixel_assert.svh"
    localparam int unsigned STEPS = SQ_STEPS;
    localparam int unsigned LAST  = STEPS - 1;
    localparam int unsigned V_W   = 2 * ROOT_W;

    logic             r_v    [STEPS];
    logic [REM_W-1:0] r_rem  [STEPS];
    logic [ROOT_W-1:0] r_q   [STEPS];
    logic [W_W-1:0]   r_w    [STEPS];
    t_side            r_side [STEPS];

    for (genvar g = 0; g < STEPS; g++) begin : g_stage
        logic pv;
        logic [REM_W-1:0] prem;
        logic [ROOT_W-1:0] pq;
        logic [W_W-1:0] pw;
        t_side pside;
        logic [V_W-1:0] v;
        logic [1:0] pair;
        logic [REM_W+1:0] sh, trial;
        logic fit;
        logic [REM_W-1:0] n_rem;
        logic [ROOT_W-1:0] n_q;

        if (g == 0) begin : g_first
            assign pv    = i_valid;
            assign prem  = '0;
            assign pq    = '0;
            assign pw    = i_w;
            assign pside = i_side;
        end else begin : g_next
            assign pv    = r_v[g-1];
            assign prem  = r_rem[g-1];
            assign pq    = r_q[g-1];
            assign pw    = r_w[g-1];
            assign pside = r_side[g-1];
        end

        // trial subtract of the next root bit
        assign v     = {pw, 32'b0};
        assign pair  = v[2*(STEPS-1-g)+1 -: 2];
        assign sh    = {prem, pair};
        assign trial = (REM_W+2)'({pq, 2'b01});
        assign fit   = (sh >= trial);
        assign n_rem = fit ? REM_W'(sh - trial) : REM_W'(sh);
        assign n_q   = {pq[ROOT_W-2:0], fit};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= pv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= n_rem;
                r_q[g]    <= n_q;
                r_w[g]    <= pw;
                r_side[g] <= pside;
            end
        end
    end

    assign o_valid = r_v[LAST];
    assign o_root  = r_q[LAST];
    assign o_side  = r_side[LAST];

    // root is the floor of the square root
    `SARP_ASSERT_IMP(a_root_low, i_clk, i_rst_n, r_v[LAST],
        (64'(r_q[LAST]) * 64'(r_q[LAST])) <= 64'({r_w[LAST], 32'b0}))
    `SARP_ASSERT_IMP(a_root_high, i_clk, i_rst_n, r_v[LAST],
        ((64'(r_q[LAST]) + 64'd1) * (64'(r_q[LAST]) + 64'd1)) > 64'({r_w[LAST], 32'b0}))
    `SARP_ASSERT_NXT(a_root_hold, i_clk, i_rst_n, !i_en,
        $stable(r_q[LAST]) && $stable(r_v[LAST]))
endmodule
`default_nettype wire

>>> rtl/sarp_polar.sv
// tail stages: polar cap edges, ring and position, final pixel select
`default_nettype none
module sarp_polar
    import sarp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [ROOT_W-1:0] i_root,
    input  t_side                  i_side,
    output logic                   o_valid,
    output logic [PIX_W-1:0]       o_pix
);
    // stage 1: scaled root and azimuth fractions
    logic r1_v;
    logic [44:0] r1_t;
    logic [29:0] r1_f;
    logic [30:0] r1_u;
    t_side r1_side;

    // stage 2: partial products
    logic r2_v;
    logic [52:0] r2_pf_lo;
    logic [51:0] r2_pf_hi;
    logic [53:0] r2_pu_lo;
    logic [52:0] r2_pu_hi;
    t_side r2_side;

    // stage 3: edge indexes
    logic r3_v;
    logic [14:0] r3_jp, r3_jm;
    t_side r3_side;
    logic [75:0] sf, su;

    assign sf = 76'({r2_pf_hi, 23'b0}) + 76'(r2_pf_lo);
    assign su = 76'({r2_pu_hi, 23'b0}) + 76'(r2_pu_lo);

    // stage 4: ring number
    logic r4_v;
    logic [14:0] r4_ir;
    t_side r4_side;

    // stage 5: position and ring offset products
    logic r5_v;
    logic [16:0] r5_ip;
    logic [PIX_W-1:0] r5_q;
    t_side r5_side;
    logic [46:0] ipm;
    logic [15:0] iro;
    logic [30:0] qm;

    assign ipm = r4_side.a * r4_ir;
    assign iro = r4_side.north ? ({1'b0, r4_ir} - 16'd1) : ({1'b0, r4_ir} + 16'd1);
    assign qm  = r4_ir * iro;

    // stage 6: final pixel
    logic r6_v;
    logic [PIX_W-1:0] r6_pix;
    logic [PIX_W-1:0] n12, q2, pix_p;

    always_comb begin
        n12   = 30'({r5_side.nsq, 3'b000}) + 30'({r5_side.nsq, 2'b00});
        q2    = {r5_q[PIX_W-2:0], 1'b0};
        pix_p = r5_side.north ? (q2 + 30'(r5_ip)) : (n12 - q2 + 30'(r5_ip));
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_t    <= i_side.n * i_root;
            r1_f    <= i_side.a[29:0];
            r1_u    <= 31'h4000_0000 - {1'b0, i_side.a[29:0]};
            r1_side <= i_side;

            r2_pf_lo <= r1_f * r1_t[22:0];
            r2_pf_hi <= r1_f * r1_t[44:23];
            r2_pu_lo <= r1_u * r1_t[22:0];
            r2_pu_hi <= r1_u * r1_t[44:23];
            r2_side  <= r1_side;

            r3_jp   <= sf[75:61];
            r3_jm   <= su[75:61];
            r3_side <= r2_side;

            r4_ir   <= r3_jp + r3_jm + 15'd1;
            r4_side <= r3_side;

            r5_ip   <= ipm[46:30];
            r5_q    <= qm[PIX_W-1:0];
            r5_side <= r4_side;

            r6_pix  <= r5_side.eq ? r5_side.pix_e : pix_p;
        end
    end

    assign o_valid = r6_v;
    assign o_pix   = r6_pix;
endmodule
`default_nettype wire

>>> rtl/sarp_obuf.sv
// two-entry output buffer that decouples the pipeline from the result stall
`default_nettype none
module sarp_obuf
    import sarp_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [PIX_W-1:0] i_data,
    output logic                  o_full,
    output logic                  o_tvalid,
    input  wire logic             i_tready,
    output logic [PIX_W-1:0]      o_tdata
);
`include "sphere_angle_to_ring_pixel_assert.svh"
    logic [1:0] r_count, n_count;
    logic [PIX_W-1:0] r_d0, r_d1, n_d0, n_d1;
    logic pop;

    assign pop = (r_count != 2'd0) && i_tready;

    // slot update
    always_comb begin
        n_count = r_count;
        n_d0    = r_d0;
        n_d1    = r_d1;
        case (r_count)
            2'd0: begin
                if (i_push) begin
                    n_d0    = i_data;
                    n_count = 2'd1;
                end
            end
            2'd1: begin
                if (i_push && pop) begin
                    n_d0 = i_data;
                end else if (i_push) begin
                    n_d1    = i_data;
                    n_count = 2'd2;
                end else if (pop) begin
                    n_count = 2'd0;
                end
            end
            2'd2: begin
                if (pop) begin
                    n_d0    = r_d1;
                    n_count = 2'd1;
                end
            end
            default: begin
                n_count = 2'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d0 <= n_d0;
        r_d1 <= n_d1;
    end

    assign o_full   = (r_count == 2'd2);
    assign o_tvalid = (r_count != 2'd0);
    assign o_tdata  = r_d0;

    `SARP_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, i_push, r_count != 2'd2)
    `SARP_ASSERT_IMP(a_count_range, i_clk, i_rst_n, 1'b1, r_count != 2'd3)
    `SARP_ASSERT_NXT(a_count_up, i_clk, i_rst_n, i_push && !pop,
        r_count == 2'($past(r_count) + 2'd1))
endmodule
`default_nettype wire

>>> rtl/sphere_angle_to_ring_pixel.sv
// Ring-ordered equal-area sphere pixel lookup: takes cos(theta) in signed Q1.30 and the
// azimuth as an unsigned 32-bit fraction of a turn, and returns the ring-scheme pixel
// number at the configured resolution (1..8192, 0 acts as 1, larger values as 8192).
// One direction is accepted every cycle while the output buffer is not full; the polar caps
// are served by a 31-stage bit-per-stage square root, with six stages before it and six
// after. A two-entry output buffer lets requests keep flowing while a result waits; the
// pipeline holds only when that buffer is full. Write the resolution only while no
// request is in flight.
`default_nettype none
module sphere_angle_to_ring_pixel
    import sarp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request channel
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [63:0] i_s_axis_tdata,  // [31:0] cos_theta, [63:32] azimuth_turns
    // result channel
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [31:0]      o_m_axis_tdata,  // [29:0] pixel_index, [31:30] zero
    // resolution write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [13:0] i_cfg_data       // [13:0] resolution
);
    logic [RES_W-1:0] r_resolution, n_eff;
    logic en, full;
    logic e_valid, s_valid, p_valid;
    logic [W_W-1:0] e_w;
    t_side e_side, s_side;
    logic [ROOT_W-1:0] s_root;
    logic [PIX_W-1:0] p_pix, ob_data;

    // resolution register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_resolution <= RES_W'(1);
        end else if (i_cfg_valid) begin
            r_resolution <= i_cfg_data;
        end
    end
    assign o_cfg_ready = 1'b1;

    // clamp to the legal range
    always_comb begin
        if (r_resolution == '0) begin
            n_eff = RES_W'(1);
        end else if (r_resolution > RES_W'(MAX_RES)) begin
            n_eff = RES_W'(MAX_RES);
        end else begin
            n_eff = r_resolution;
        end
    end

    // pipeline advances unless the output buffer is full
    assign en = !full;
    assign o_s_axis_tready = en;

    sarp_equ u_equ (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_s_axis_tvalid),
        .i_z     (i_s_axis_tdata[31:0]),
        .i_a     (i_s_axis_tdata[63:32]),
        .i_n     (n_eff),
        .o_valid (e_valid),
        .o_w     (e_w),
        .o_side  (e_side)
    );

    sarp_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (e_valid),
        .i_w     (e_w),
        .i_side  (e_side),
        .o_valid (s_valid),
        .o_root  (s_root),
        .o_side  (s_side)
    );

    sarp_polar u_polar (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_valid),
        .i_root  (s_root),
        .i_side  (s_side),
        .o_valid (p_valid),
        .o_pix   (p_pix)
    );

    sarp_obuf u_obuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (p_valid && en),
        .i_data   (p_pix),
        .o_full   (full),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_tdata  (ob_data)
    );

    assign o_m_axis_tdata = {2'b00, ob_data};
endmodule
`default_nettype wire
